// ===== rtl/aled_pkg.sv =====
// Shared types and constants for the addressable LED bit encoder.
// No dependencies; imported by every module and by aled_cfg_if.
`timescale 1ns / 1ps

package aled_pkg;

	// Bit periods sent for one LED item
	localparam int BITS_PER_LED = 24;
	localparam int CNT_W = $clog2(BITS_PER_LED);

	// Configuration port
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_BLOCKS = 8'd3;

	localparam logic [7:0] RST_BRIGHTNESS   = 8'd255;
	localparam logic [7:0] RST_PULSE_LOW    = 8'd29;
	localparam logic [7:0] RST_PULSE_HIGH   = 8'd58;
	localparam logic [7:0] RST_RESET_BLOCKS = 8'd3;

	// Item action codes
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_GAP   = 1'b1;

	// Register file contents handed to front and back
	typedef struct packed {
		logic [7:0] brightness;
		logic [7:0] pulse_low;
		logic [7:0] pulse_high;
		logic [7:0] reset_blocks;
	} cfg_regs_t;

	// One classified item waiting to be serialized
	typedef struct packed {
		logic [BITS_PER_LED-1:0] bits;
		logic                    gap;
		logic                    done;
	} led_job_t;

endpackage

// ===== rtl/aled_if.sv =====
// Handshake interfaces: pixel input, bit-period output, configuration write.
// Depends on aled_pkg.
`timescale 1ns / 1ps

interface aled_pix_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, action, red, green, blue, input ready);
	modport sink (input valid, action, red, green, blue, output ready);
endinterface

interface aled_period_if;
	logic       valid;
	logic       ready;
	logic [7:0] duty;
	logic       block_end;
	logic       frame_done;

	modport source (output valid, duty, block_end, frame_done, input ready);
	modport sink (input valid, duty, block_end, frame_done, output ready);
endinterface

interface aled_cfg_if import aled_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/addressable_led_bit_encoder.sv =====
// Addressable LED bit encoder: pixel and gap words in, one duty code per
// bit period out. Ports: pix (sink), led (source), cfg (write sink).
// Registers: 0 brightness, 1 pulse_low, 2 pulse_high, 3 reset_blocks; any
// other index is ignored. cfg.ready is always high; write only when idle.
// A pixel word is scaled by brightness/255 per channel and sent as 24
// periods, green, red, blue, MSB first (pulse_high for a one, pulse_low for
// a zero). A gap word sends 24 zero periods; the gap word that completes
// reset_blocks gaps flags frame_done on its last period.
// The first period of a word passes the front stage register, the queue,
// the sequencer load and the output register. Throughput: the back-end bit
// counter emits one period a cycle while led.ready does not stall it; words
// follow one another with no idle period between them.
// A stalled led.ready holds the output register; the queue of QUEUE_DEPTH
// words plus the front stage keep accepting until full.
// Reset loads the register defaults, clears the gap count, empties the queue.
`timescale 1ns / 1ps

module addressable_led_bit_encoder import aled_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	aled_cfg_if.sink      cfg,
	aled_pix_if.sink      pix,
	aled_period_if.source led
);

	cfg_regs_t cfg_q;
	logic      push_valid;
	logic      push_ready;
	led_job_t  push_data;
	logic      pop_valid;
	logic      pop_ready;
	led_job_t  pop_data;

	assign cfg.ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness   <= RST_BRIGHTNESS;
			cfg_q.pulse_low    <= RST_PULSE_LOW;
			cfg_q.pulse_high   <= RST_PULSE_HIGH;
			cfg_q.reset_blocks <= RST_RESET_BLOCKS;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BRIGHTNESS:   cfg_q.brightness   <= cfg.data;
				REG_PULSE_LOW:    cfg_q.pulse_low    <= cfg.data;
				REG_PULSE_HIGH:   cfg_q.pulse_high   <= cfg.data;
				REG_RESET_BLOCKS: cfg_q.reset_blocks <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	aled_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg_regs   (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	aled_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	aled_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg_regs  (cfg_q),
		.led       (led)
	);

endmodule

// ===== rtl/aled_front.sv =====
// Front end: accepts pixel and gap words, scales colours, tracks the gap count.
// Depends on aled_pkg and aled_pix_if; feeds aled_queue.
`timescale 1ns / 1ps

module aled_front import aled_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	aled_pix_if.sink       pix,
	input  cfg_regs_t      cfg_regs,
	output logic           push_valid,
	input  logic           push_ready,
	output led_job_t       push_data
);

	logic        valid_s1;
	logic        gap_s1;
	logic        done_s1;
	logic [15:0] prod_r_s1;
	logic [15:0] prod_g_s1;
	logic [15:0] prod_b_s1;
	logic [7:0]  gap_count_q;

	logic        accept;
	logic [8:0]  gap_next;
	logic        gap_done;

	assign pix.ready = !valid_s1 || push_ready;
	assign accept    = pix.valid && pix.ready;

	// Gap completes once the count reaches the programmed length
	assign gap_next = {1'b0, gap_count_q} + 9'd1;
	assign gap_done = gap_next >= {1'b0, cfg_regs.reset_blocks};

	// Stage 1 control and gap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			gap_count_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (pix.action == ACT_PIXEL || gap_done) begin
					gap_count_q <= '0;
				end else begin
					gap_count_q <= gap_next[7:0];
				end
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage 1 payload: channel times brightness
	always_ff @(posedge clk) begin
		if (accept) begin
			gap_s1    <= (pix.action == ACT_GAP);
			done_s1   <= (pix.action == ACT_GAP) && gap_done;
			prod_r_s1 <= pix.red * cfg_regs.brightness;
			prod_g_s1 <= pix.green * cfg_regs.brightness;
			prod_b_s1 <= pix.blue * cfg_regs.brightness;
		end
	end

	// Divide an 8x8 product by 255, exact over the whole product range
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	// Hand the word to the queue, green then red then blue
	assign push_valid     = valid_s1;
	assign push_data.bits = gap_s1 ? '0 :
		{div255(prod_g_s1), div255(prod_r_s1), div255(prod_b_s1)};
	assign push_data.gap  = gap_s1;
	assign push_data.done = done_s1;

endmodule

// ===== rtl/aled_queue.sv =====
// Small register queue between front and back ends.
// Depends on aled_pkg for the entry type.
`timescale 1ns / 1ps

module aled_queue import aled_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  led_job_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output led_job_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	led_job_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W_Q-1:0] count_q;

	logic push;
	logic pop;

	assign push_ready = count_q != CNT_W_Q'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/aled_back.sv =====
// Back end: serializes one queued word into bit-period duty codes.
// Depends on aled_pkg and aled_period_if; fed by aled_queue.
`timescale 1ns / 1ps

module aled_back import aled_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  led_job_t      pop_data,
	input  cfg_regs_t     cfg_regs,
	aled_period_if.source led
);

	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_LED - 1);

	logic                    busy_q;
	logic [BITS_PER_LED-1:0] bits_q;
	logic                    gap_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	logic [7:0]              duty_q;
	logic                    block_end_q;
	logic                    frame_done_q;

	logic out_free;
	logic emit;
	logic last;

	assign out_free  = !out_valid_q || led.ready;
	assign emit      = busy_q && out_free;
	assign last      = cnt_q == LAST_BIT;
	assign pop_ready = !busy_q || (out_free && last);

	// Sequencer control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= busy_q;
			end
			if (pop_ready && pop_valid) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Load the word, shift it out MSB first, drive the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			duty_q       <= gap_q ? 8'd0 :
				(bits_q[BITS_PER_LED-1] ? cfg_regs.pulse_high : cfg_regs.pulse_low);
			block_end_q  <= last;
			frame_done_q <= last && done_q;
		end
		if (pop_ready && pop_valid) begin
			bits_q <= pop_data.bits;
			gap_q  <= pop_data.gap;
			done_q <= pop_data.done;
		end else if (emit) begin
			bits_q <= {bits_q[BITS_PER_LED-2:0], 1'b0};
		end
	end

	assign led.valid      = out_valid_q;
	assign led.duty       = duty_q;
	assign led.block_end  = block_end_q;
	assign led.frame_done = frame_done_q;

endmodule
